/* src/kwm_pkg.sv */
package kwm_pkg;

  // Fixed field widths of the item, result and lane count channels.
  localparam int unsigned LaneW  = 3;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CntW   = 4;

  // The lane field addresses at most this many lanes.
  localparam int unsigned LaneSpan = 8;

  // Lane count after reset.
  localparam logic [CntW-1:0] CntReset = 4'd8;

  // Result kinds.
  localparam logic KindElem = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // Running selection handed from one cell to the next.
  typedef struct packed {
    logic              found;    // some unfinished lane holds a head
    logic              blocked;  // some unfinished lane still awaits its head
    logic [ValueW-1:0] value;    // smallest head so far
    logic [LaneW-1:0]  idx;      // lane of that head
  } kwm_chain_t;

  // Controls broadcast from the top level to every cell.
  typedef struct packed {
    logic              accept;     // an item is accepted this cycle
    logic [LaneW-1:0]  lane;
    logic [ValueW-1:0] value;
    logic              lane_end;
    logic              take;       // an element leaves, from lane best_idx
    logic [LaneW-1:0]  best_idx;
    logic              clear_all;  // end of merge
  } kwm_bcast_t;

  // Status of one cell.
  typedef struct packed {
    logic valid;
    logic finished;
  } kwm_stat_t;

endpackage

/* src/kwm_if.sv */
// Item channel into the merge.
interface kwm_item_if;
  import kwm_pkg::*;
  logic              valid;
  logic              ready;
  logic [LaneW-1:0]  lane;
  logic [ValueW-1:0] value;
  logic              lane_end;
  modport source (output valid, lane, value, lane_end, input ready);
  modport sink (input valid, lane, value, lane_end, output ready);
endinterface

// Result channel out of the merge.
interface kwm_result_if;
  import kwm_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ValueW-1:0] out_value;
  logic [LaneW-1:0]  source_lane;
  modport source (output valid, kind, out_value, source_lane, input ready);
  modport sink (input valid, kind, out_value, source_lane, output ready);
endinterface

// Write channel of the lane count register.
interface kwm_cfg_if;
  import kwm_pkg::*;
  logic            valid;
  logic            ready;
  logic [CntW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* src/kwm_cell.sv */
module kwm_cell
  import kwm_pkg::*;
#(
  parameter logic [LaneW-1:0] IDX = 3'd0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_use_i,
  input  kwm_bcast_t bcast_i,
  input  kwm_chain_t chain_i,
  output kwm_chain_t chain_o,
  output kwm_stat_t  stat_o
);

  logic              valid_q, valid_d;
  logic              fin_q, fin_d;
  logic [ValueW-1:0] head_q, head_d;
  logic              valid_mid;
  logic              fin_mid;
  logic              wr;

  // Selection: pass the running minimum on, replacing it on a strictly smaller head.
  always_comb begin
    chain_o = chain_i;
    if (in_use_i && !fin_q) begin
      if (!valid_q) begin
        chain_o.blocked = 1'b1;
      end else if (!chain_i.found || ($signed(head_q) < $signed(chain_i.value))) begin
        chain_o.found = 1'b1;
        chain_o.value = head_q;
        chain_o.idx   = IDX;
      end
    end
  end

  // The pending check acts first, then the newly accepted item lands.
  always_comb begin
    valid_mid = valid_q && !bcast_i.clear_all &&
                !(bcast_i.take && (bcast_i.best_idx == IDX));
    fin_mid   = fin_q && !bcast_i.clear_all;
    wr        = bcast_i.accept && (bcast_i.lane == IDX) && in_use_i &&
                !valid_mid && !fin_mid;
    valid_d   = valid_mid;
    fin_d     = fin_mid;
    head_d    = head_q;
    if (wr) begin
      if (bcast_i.lane_end) begin
        fin_d = 1'b1;
      end else begin
        valid_d = 1'b1;
        head_d  = bcast_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      fin_q   <= fin_d;
    end
  end

  // Head value is only read while valid.
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
  end

  assign stat_o.valid    = valid_q;
  assign stat_o.finished = fin_q;

endmodule

/* src/k_way_sorted_merge.sv */
// Merges up to eight ascending streams of signed 32-bit values into one ascending
// stream. Each item carries the next element of one lane, or an end mark for it;
// items for lanes outside the count, or for lanes that already hold a head or
// have ended, are dropped. Once every unfinished lane in use holds a head, the
// smallest head leaves as an element (ties go to the lowest lane) and that lane
// is awaited again; when all lanes in use have ended, an end result is sent and
// the block clears itself for the next merge. One item is taken per cycle; the
// input stalls only while a due result waits for a full output register. An item
// lands in its lane cell, then any result is registered. The clock period is set by
// the row of lane cells that passes the running minimum through one signed 32-bit
// compare per lane. The lane count may be written only while the block is idle.
module k_way_sorted_merge
  import kwm_pkg::*;
#(
  parameter int unsigned LANES = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  kwm_item_if.sink     item_i,
  kwm_cfg_if.sink      cfg_i,
  kwm_result_if.source result_o
);

  localparam int unsigned NCell = (LANES < LaneSpan) ? LANES : LaneSpan;
  localparam logic [CntW-1:0] NCellCnt = CntW'(NCell);

  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   n_act;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic              kind_q;
  logic [ValueW-1:0] value_q;
  logic [LaneW-1:0]  lane_q;
  logic              accept;
  logic              out_free;
  logic              emit;
  logic              is_end;
  logic              fire;
  kwm_bcast_t        bcast;
  kwm_chain_t        chain [NCell+1];
  kwm_stat_t         stat  [NCell];
  logic [NCell-1:0]  in_use;
  logic [NCell-1:0]  valid_vec;
  logic [NCell-1:0]  fin_vec;

  // Lane count register.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CntReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      cnt_q <= cfg_i.data;
    end
  end

  // Effective count: zero acts as one, and it saturates at the number of cells.
  always_comb begin
    n_act = cnt_q;
    if (cnt_q == '0) begin
      n_act = CntW'(1);
    end else if (cnt_q > NCellCnt) begin
      n_act = NCellCnt;
    end
  end

  // Check pending from the last accepted item, and the handshakes.
  assign chain[0] = '{found: 1'b0, blocked: 1'b0, value: '0, idx: '0};
  assign emit     = !chain[NCell].blocked;
  assign is_end   = !chain[NCell].found;
  assign out_free = !out_valid_q || result_o.ready;
  assign fire     = pend_q && (!emit || out_free);
  assign item_i.ready = !pend_q || fire;
  assign accept   = item_i.valid && item_i.ready;

  always_comb begin
    bcast.accept    = accept;
    bcast.lane      = item_i.lane;
    bcast.value     = item_i.value;
    bcast.lane_end  = item_i.lane_end;
    bcast.take      = fire && emit && !is_end;
    bcast.best_idx  = chain[NCell].idx;
    bcast.clear_all = fire && emit && is_end;
  end

  // Row of lane cells.
  for (genvar i = 0; i < NCell; i++) begin : g_cell
    assign in_use[i]    = CntW'(i) < n_act;
    assign valid_vec[i] = stat[i].valid;
    assign fin_vec[i]   = stat[i].finished;
    kwm_cell #(
      .IDX(LaneW'(i))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .in_use_i(in_use[i]),
      .bcast_i (bcast),
      .chain_i (chain[i]),
      .chain_o (chain[i+1]),
      .stat_o  (stat[i])
    );
  end

  // Control of the pending check and the output register.
  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = 1'b1;
    end else if (fire) begin
      pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire && emit) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      if (is_end) begin
        kind_q  <= KindEnd;
        value_q <= '0;
        lane_q  <= '0;
      end else begin
        kind_q  <= KindElem;
        value_q <= chain[NCell].value;
        lane_q  <= chain[NCell].idx;
      end
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.kind        = kind_q;
  assign result_o.out_value   = value_q;
  assign result_o.source_lane = lane_q;

`ifndef SYNTHESIS
  // A due result never overtakes a full output register.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && emit && !out_free) |-> !item_i.ready)
    else $error("item taken while a due result was blocked");

  // The end of a merge leaves every lane cleared unless a new item lands.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bcast.clear_all && !accept) |=> (valid_vec == '0) && (fin_vec == '0))
    else $error("lane state survived the end of merge");

  // An emitted element comes from a lane in use.
  a_lane_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcast.take |-> (CntW'(bcast.best_idx) < n_act) && valid_vec[bcast.best_idx])
    else $error("element taken from a lane without a head");

  // An end result carries zero payload.
  a_end_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.kind == KindEnd)) |->
      (result_o.out_value == '0) && (result_o.source_lane == '0))
    else $error("end result with nonzero payload");
`endif

endmodule

/* dv/kwm_checker.sv */
`timescale 1ns / 1ps

// Watches the item, count and result channels of the merge. It keeps its own
// copy of the lane heads and the lane count, works out the result that each
// accepted item causes, and compares each accepted result with the oldest one
// still owed.
module kwm_checker
  import kwm_pkg::*;
#(
  parameter int unsigned LANES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kwm_item_if         item_mon,
  kwm_cfg_if          cfg_mon,
  kwm_result_if       res_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output logic        clean_o
);

  typedef struct packed {
    logic              kind;
    logic [ValueW-1:0] value;
    logic [LaneW-1:0]  lane;
  } merged_t;

  logic [ValueW-1:0] head_val  [LaneSpan];
  logic              head_full [LaneSpan];
  logic              lane_done [LaneSpan];
  logic [CntW-1:0]   lane_count;
  merged_t           merged_q [$];
  merged_t           want;

  // Lanes that take part: a count of zero means one, and the count saturates
  // at the lane parameter and at what the lane field can address.
  function automatic int unsigned lanes_merged();
    int unsigned n;
    n = (lane_count == '0) ? 1 : lane_count;
    if (n > LANES) n = LANES;
    if (n > LaneSpan) n = LaneSpan;
    return n;
  endfunction

  task automatic clear_heads();
    for (int k = 0; k < LaneSpan; k++) begin
      head_full[k] = 1'b0;
      lane_done[k] = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [ValueW-1:0] got,
                                 input logic [ValueW-1:0] exp_val);
    $display("%0t: merge mismatch on %s: got %0h, expected %0h", $time, what, got,
             exp_val);
    fail_count_o++;
  endtask

  // Applies one item to the lane heads and queues the result it causes, if any.
  task automatic merge_item(input logic [LaneW-1:0] lane, input logic [ValueW-1:0] value,
                            input logic lane_end);
    int unsigned span;
    logic        open_lane;
    logic        waiting;
    logic        have_best;
    int unsigned best;
    span = lanes_merged();
    open_lane = 1'b0;
    waiting = 1'b0;
    have_best = 1'b0;
    best = 0;
    // Items for lanes outside the count, already full or finished are dropped.
    if (lane < span && !head_full[lane] && !lane_done[lane]) begin
      if (lane_end) begin
        lane_done[lane] = 1'b1;
      end else begin
        head_val[lane] = value;
        head_full[lane] = 1'b1;
      end
    end
    // Smallest head over the unfinished lanes; ties stay with the lower lane.
    for (int unsigned k = 0; k < span; k++) begin
      if (!lane_done[k]) begin
        open_lane = 1'b1;
        if (!head_full[k]) begin
          waiting = 1'b1;
        end else if (!have_best || $signed(head_val[k]) < $signed(head_val[best])) begin
          best = k;
          have_best = 1'b1;
        end
      end
    end
    if (!open_lane) begin
      clear_heads();
      merged_q.push_back('{kind: KindEnd, value: '0, lane: '0});
    end else if (!waiting) begin
      head_full[best] = 1'b0;
      merged_q.push_back('{kind: KindElem, value: head_val[best], lane: best[LaneW-1:0]});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_heads();
      for (int k = 0; k < LaneSpan; k++) head_val[k] = '0;
      lane_count = CntReset;
      merged_q.delete();
      fail_count_o = 0;
    end else begin
      // Results first: none of them can stem from an item taken at this edge.
      if (res_mon.valid && res_mon.ready) begin
        if (merged_q.size() == 0) begin
          report_mismatch("result with nothing owed", res_mon.out_value, '0);
        end else begin
          want = merged_q.pop_front();
          if (res_mon.kind !== want.kind) begin
            report_mismatch("kind", ValueW'(res_mon.kind), ValueW'(want.kind));
          end
          if (res_mon.out_value !== want.value) begin
            report_mismatch("out_value", res_mon.out_value, want.value);
          end
          if (res_mon.source_lane !== want.lane) begin
            report_mismatch("source_lane", ValueW'(res_mon.source_lane), ValueW'(want.lane));
          end
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        merge_item(item_mon.lane, item_mon.value, item_mon.lane_end);
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        lane_count = cfg_mon.data;
      end
    end
    // Status for the stimulus side.
    pending_o = merged_q.size();
    clean_o = 1'b1;
    for (int unsigned k = 0; k < lanes_merged(); k++) begin
      if (head_full[k] || lane_done[k]) clean_o = 1'b0;
    end
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import kwm_pkg::*;

  localparam int unsigned LANES = 8;
  localparam int unsigned ItemGoal = 2000;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SeqMax = 7;
  localparam logic [ValueW-1:0] ValMin = 32'h8000_0000;
  localparam logic [ValueW-1:0] ValMax = 32'h7fff_ffff;
  localparam longint ValMaxL = 64'sd2147483647;
  localparam longint ValMinL = -64'sd2147483648;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  int unsigned     fail_count;
  int unsigned     pending;
  logic            merge_clean;
  bit              no_idle = 1'b0;
  bit              hold_req = 1'b0;
  int unsigned     items_sent = 0;
  int unsigned     idle_run = 0;
  logic [CntW-1:0] lane_count = CntReset;

  kwm_item_if   item_ch ();
  kwm_cfg_if    cfg_ch ();
  kwm_result_if result_ch ();

  k_way_sorted_merge #(.LANES(LANES)) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_ch),
    .cfg_i   (cfg_ch),
    .result_o(result_ch)
  );

  kwm_checker #(.LANES(LANES)) merge_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_mon    (item_ch),
    .cfg_mon     (cfg_ch),
    .res_mon     (result_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .clean_o     (merge_clean)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Ends the run when nothing has moved on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (item_ch.valid && item_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      idle_run <= 0;
    end else if (idle_run >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        result_ch.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      result_ch.ready = no_idle || ($urandom_range(0, 99) >= 18);
    end
  end

  function automatic int unsigned lanes_active();
    int unsigned n;
    n = (lane_count == '0) ? 1 : lane_count;
    if (n > LANES) n = LANES;
    if (n > LaneSpan) n = LaneSpan;
    return n;
  endfunction

  // Offers one item, now and then after a short gap, and returns once taken.
  task automatic send_item(input logic [LaneW-1:0] lane, input logic [ValueW-1:0] value,
                           input logic lane_end);
    int unsigned gap;
    if (!no_idle && $urandom_range(0, 99) < 18) begin
      item_ch.valid = 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk_i);
    end
    item_ch.valid = 1'b1;
    item_ch.lane = lane;
    item_ch.value = value;
    item_ch.lane_end = lane_end;
    do @(posedge clk_i); while (!item_ch.ready);
    @(negedge clk_i);
  endtask

  // Stops sending and waits until every owed result is out and the pipe is empty.
  task automatic go_quiet();
    item_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_count(input logic [CntW-1:0] count);
    go_quiet();
    cfg_ch.valid = 1'b1;
    cfg_ch.data = count;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
    lane_count = count;
  endtask

  // End marks in turn over the lanes in use until no lane holds a head or has
  // ended, so that a merge broken by noise or a cut-off cannot hang the next one.
  task automatic settle_merge();
    int unsigned rr;
    rr = 0;
    while (!merge_clean) begin
      send_item(rr[LaneW-1:0], $urandom, 1'b1);
      rr = (rr + 1) % lanes_active();
    end
  endtask

  // One merge of random ascending lanes, fed in the order the block asks for
  // them, with some noise items mixed in and now and then cut off early.
  task automatic run_merge();
    logic signed [ValueW-1:0] seq_val [LaneSpan][SeqMax];
    logic signed [ValueW-1:0] head [LaneSpan];
    int unsigned              seq_len [LaneSpan];
    int unsigned              next_pos [LaneSpan];
    bit                       holds [LaneSpan];
    int unsigned              refill_q [$];
    int unsigned              span, mode, steps, cut, best, lane;
    longint                   cur, stride;
    bit                       any;
    settle_merge();
    span = lanes_active();
    for (int unsigned k = 0; k < span; k++) begin
      seq_len[k] = $urandom_range(0, SeqMax);
      next_pos[k] = 0;
      holds[k] = 1'b0;
      mode = $urandom_range(0, 3);
      case (mode)
        0: cur = longint'($urandom_range(0, 10)) - 5;
        1: cur = longint'($signed($urandom));
        2: cur = ValMinL;
        default: cur = ValMaxL - $urandom_range(0, 3);
      endcase
      for (int unsigned j = 0; j < seq_len[k]; j++) begin
        seq_val[k][j] = cur[ValueW-1:0];
        if (mode == 0 || mode == 3) stride = $urandom_range(0, 2);
        else stride = longint'($urandom) >> $urandom_range(1, 31);
        cur = cur + stride;
        if (cur > ValMaxL) cur = ValMaxL;
      end
      refill_q.insert($urandom_range(0, refill_q.size()), k);
    end
    cut = ($urandom_range(0, 99) < 10) ? $urandom_range(1, 12) : 0;
    steps = 0;
    while (refill_q.size() != 0) begin
      if (cut != 0 && steps == cut) return;
      if ($urandom_range(0, 99) < 6) begin
        send_item(LaneW'($urandom_range(0, LaneSpan - 1)), $urandom,
                  1'($urandom_range(0, 1)));
      end
      lane = refill_q.pop_front();
      if (next_pos[lane] < seq_len[lane]) begin
        head[lane] = seq_val[lane][next_pos[lane]];
        send_item(lane[LaneW-1:0], head[lane], 1'b0);
        holds[lane] = 1'b1;
        next_pos[lane]++;
      end else begin
        send_item(lane[LaneW-1:0], $urandom, 1'b1);
      end
      steps++;
      items_sent++;
      // Once every lane has been served, the smallest head leaves and its lane
      // is the next one to refill.
      if (refill_q.size() == 0) begin
        any = 1'b0;
        best = 0;
        for (int unsigned k = 0; k < span; k++) begin
          if (holds[k] && (!any || head[k] < head[best])) begin
            best = k;
            any = 1'b1;
          end
        end
        if (any) begin
          holds[best] = 1'b0;
          refill_q.push_back(best);
        end
      end
    end
  endtask

  initial begin
    int unsigned merges;
    item_ch.valid = 1'b0;
    item_ch.lane = '0;
    item_ch.value = '0;
    item_ch.lane_end = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Two lanes: tie at the lowest value, both extremes, items for a lane
    // outside the count, for a lane that holds a head and for an ended lane.
    write_count(4'd2);
    send_item(3'd0, ValMin, 1'b0);
    send_item(3'd1, ValMin, 1'b0);
    send_item(3'd5, 32'd7, 1'b0);
    send_item(3'd1, 32'd3, 1'b0);
    send_item(3'd0, ValMax, 1'b0);
    send_item(3'd1, '0, 1'b1);
    send_item(3'd1, '0, 1'b0);
    send_item(3'd0, '0, 1'b1);

    // A count of zero merges one lane.
    write_count(4'd0);
    send_item(3'd0, 32'hffff_ffff, 1'b0);
    send_item(3'd1, 32'd5, 1'b0);
    send_item(3'd0, '0, 1'b1);

    // The largest count saturates at eight lanes; the top lane still takes part.
    write_count(4'd15);
    send_item(3'd7, 32'haaaa_5555, 1'b0);
    for (int k = 6; k >= 0; k--) send_item(k[LaneW-1:0], '0, 1'b1);
    send_item(3'd7, '0, 1'b1);

    // Random phases, each under its own lane count.
    for (int unsigned phase = 0; items_sent < ItemGoal; phase++) begin
      case (phase)
        0: write_count(4'd8);
        1: write_count(4'd1);
        2: write_count(4'd15);
        3: write_count(4'd0);
        4: write_count(4'd4);
        default: write_count(CntW'($urandom_range(0, 15)));
      endcase
      no_idle = (phase == 2);
      merges = $urandom_range(3, 6);
      for (int unsigned m = 0; m < merges; m++) begin
        // The receiver holds off while items keep coming, so the block fills.
        if (phase == 0 && m == 0) hold_req = 1'b1;
        run_merge();
        if (phase == 0 && m == 0) go_quiet();
      end
    end
    no_idle = 1'b0;

    go_quiet();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
src/kwm_pkg.sv
src/kwm_if.sv
src/kwm_cell.sv
src/k_way_sorted_merge.sv
dv/kwm_checker.sv
dv/tb.sv
